@@ src/assert_macros.svh @@
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle check failed");

`endif

@@ src/fsp_pkg.sv @@
package fsp_pkg;

   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CASE_MASK    = 8'hDF;
   localparam logic [7:0] HEX_TEN      = 8'h0A;

   typedef enum logic [2:0] {
      ESC_IDLE = 3'b001,
      ESC_HIGH = 3'b010,
      ESC_LOW  = 3'b100
   } esc_state_type;

   typedef struct packed {
      logic          value_phase;
      esc_state_type escape_phase;
      logic [7:0]    first_digit_value;
   } parse_state_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic       in_value;
      logic       field_end;
      logic       pair_end;
   } result_type;

   // digit value, wraps mod 256 for non-hex characters
   function automatic logic [7:0] hex_of(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CHAR_UPPER_A) begin
         v = (c & CASE_MASK) - CHAR_UPPER_A + HEX_TEN;
      end else begin
         v = c - CHAR_ZERO;
      end
      return v;
   endfunction

endpackage

@@ src/fsp_req_if.sv @@
interface fsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last;

   modport source (output valid, output in_byte, output last, input ready);
   modport sink (input valid, input in_byte, input last, output ready);
endinterface

@@ src/fsp_rsp_if.sv @@
interface fsp_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] out_byte;
   logic       in_value;
   logic       field_end;
   logic       pair_end;

   modport source (output valid, output has_byte, output out_byte, output in_value,
                   output field_end, output pair_end, input ready);
   modport sink (input valid, input has_byte, input out_byte, input in_value,
                 input field_end, input pair_end, output ready);
endinterface

@@ src/fsp_decoder.sv @@
module fsp_decoder (
   input  fsp_pkg::parse_state_type state,
   input  logic [7:0]               in_byte,
   input  logic                     last,
   output fsp_pkg::parse_state_type state_next,
   output fsp_pkg::result_type      result,
   output logic                     emit
);

   logic [7:0] delim;
   logic [7:0] c;
   logic [7:0] hex_c;
   logic       has;
   logic       fe;
   logic       pe;
   logic [7:0] ob;
   fsp_pkg::parse_state_type nxt;

   assign delim = state.value_phase ? fsp_pkg::CHAR_AMP : fsp_pkg::CHAR_EQUALS;
   assign c     = (in_byte == fsp_pkg::CHAR_PLUS) ? fsp_pkg::CHAR_SPACE : in_byte;
   assign hex_c = fsp_pkg::hex_of(c);

   always_comb begin
      nxt = state;
      has = 1'b0;
      fe  = 1'b0;
      pe  = 1'b0;
      ob  = 8'h00;
      if (in_byte == delim) begin
         // escape cut short by a delimiter gives a zero byte
         has              = (state.escape_phase != fsp_pkg::ESC_IDLE);
         nxt.escape_phase = fsp_pkg::ESC_IDLE;
         fe               = 1'b1;
         if (state.value_phase) begin
            pe              = 1'b1;
            nxt.value_phase = 1'b0;
         end else if (last) begin
            pe = 1'b1;
         end else begin
            nxt.value_phase = 1'b1;
         end
      end else begin
         unique case (state.escape_phase)
            fsp_pkg::ESC_IDLE: begin
               if (c == fsp_pkg::CHAR_PERCENT) begin
                  nxt.escape_phase = fsp_pkg::ESC_HIGH;
               end else begin
                  has = 1'b1;
                  ob  = c;
               end
            end
            fsp_pkg::ESC_HIGH: begin
               nxt.first_digit_value = {hex_c[3:0], 4'h0};
               nxt.escape_phase      = fsp_pkg::ESC_LOW;
            end
            fsp_pkg::ESC_LOW: begin
               has              = 1'b1;
               ob               = state.first_digit_value + hex_c;
               nxt.escape_phase = fsp_pkg::ESC_IDLE;
            end
            default: begin
               nxt.escape_phase = fsp_pkg::ESC_IDLE;
            end
         endcase
         if (last) begin
            if (nxt.escape_phase != fsp_pkg::ESC_IDLE) begin
               has = 1'b1;
               ob  = 8'h00;
            end
            fe = 1'b1;
            pe = 1'b1;
         end
      end
      if (last) begin
         nxt.value_phase       = 1'b0;
         nxt.escape_phase      = fsp_pkg::ESC_IDLE;
         nxt.first_digit_value = 8'h00;
      end
   end

   assign state_next       = nxt;
   assign emit             = has | fe;
   assign result.has_byte  = has;
   assign result.out_byte  = has ? ob : 8'h00;
   assign result.in_value  = state.value_phase;
   assign result.field_end = fe;
   assign result.pair_end  = pe;

endmodule

@@ src/form_query_string_splitter.sv @@
// A result is registered and appears on rsp_ch in the cycle after its byte is taken.
// Throughput: one byte per cycle; the single result register is refilled in
// the cycle it is drained, so only a stalled rsp_ch holds off req_ch.
// Some bytes (a percent sign, a first escape digit) give no result.
// Reset (synchronous, active high) returns the parser to name collection with
// no escape pending and empties the result register.
module form_query_string_splitter (
   input logic      clock,
   input logic      reset,
   fsp_req_if.sink  req_ch,
   fsp_rsp_if.source rsp_ch
);

   fsp_pkg::parse_state_type state_ff;
   fsp_pkg::parse_state_type state_in;
   fsp_pkg::result_type      result_ff;
   fsp_pkg::result_type      result_in;
   logic                     rsp_valid_ff;
   logic                     emit;
   logic                     accept;

   fsp_decoder u_decoder (
      .state      (state_ff),
      .in_byte    (req_ch.in_byte),
      .last       (req_ch.last),
      .state_next (state_in),
      .result     (result_in),
      .emit       (emit)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.value_phase       <= 1'b0;
         state_ff.escape_phase      <= fsp_pkg::ESC_IDLE;
         state_ff.first_digit_value <= 8'h00;
         rsp_valid_ff               <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.has_byte  = result_ff.has_byte;
   assign rsp_ch.out_byte  = result_ff.out_byte;
   assign rsp_ch.in_value  = result_ff.in_value;
   assign rsp_ch.field_end = result_ff.field_end;
   assign rsp_ch.pair_end  = result_ff.pair_end;

endmodule

@@ src/fsp_checker.sv @@
`include "assert_macros.svh"

module fsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_has_byte,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_field_end,
   input logic       rsp_pair_end
);

   logic        rsp_stalled;
   logic [10:0] rsp_payload;

   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_has_byte, rsp_out_byte, rsp_field_end, rsp_pair_end};

   `ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

   // every item carries a byte or a close mark
   `ASSERT_IMPLIES(a_not_empty, clock, reset, rsp_valid, rsp_has_byte || rsp_field_end)

   `ASSERT_IMPLIES(a_pair_closes_field, clock, reset, rsp_valid && rsp_pair_end, rsp_field_end)

   `ASSERT_IMPLIES(a_no_byte_zero, clock, reset, rsp_valid && !rsp_has_byte, rsp_out_byte == 8'h00)

   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))

endmodule

bind form_query_string_splitter fsp_checker u_fsp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_has_byte  (rsp_ch.has_byte),
   .rsp_out_byte  (rsp_ch.out_byte),
   .rsp_field_end (rsp_ch.field_end),
   .rsp_pair_end  (rsp_ch.pair_end)
);
